FILE: rtl/thomas_fermi_euler_integrator_core_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Thomas-Fermi Euler integrator
// Define ASSERT_OFF to compile the checks out.
// ----------------------------------------------------------------------------
`ifndef THOMAS_FERMI_EULER_INTEGRATOR_CORE_ASSERT_SVH
`define THOMAS_FERMI_EULER_INTEGRATOR_CORE_ASSERT_SVH

`ifndef ASSERT_OFF

// checked only while out of reset
`define TFEI_ASSERT(lbl, clk_s, rst_ns, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_ns) prop) \
    else $error("tfei assertion failed");

// checked on every edge, reset included
`define TFEI_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("tfei assertion failed");

`else

`define TFEI_ASSERT(lbl, clk_s, rst_ns, prop)
`define TFEI_ASSERT_ALWAYS(lbl, clk_s, prop)

`endif

`endif

FILE: rtl/tfei_pkg.sv
// ----------------------------------------------------------------------------
// tfei_pkg
// Microcode format, control program and shared constants of the integrator.
// ----------------------------------------------------------------------------
`default_nettype none

package tfei_pkg;

  localparam int PC_W      = 5;
  localparam int CNT_W     = 6;
  localparam int DIV_STEPS = 64;   // one quotient bit per step
  localparam int SQRT_STEPS = 32;  // one root bit per step

  typedef logic [PC_W-1:0]  pc_t;
  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [1:0]       phase_t;

  localparam phase_t PH_IDLE   = 2'd0;
  localparam phase_t PH_FIRST  = 2'd1;
  localparam phase_t PH_SECOND = 2'd2;
  localparam phase_t PH_LATER  = 2'd3;

  localparam logic signed [31:0] PHI_ONE        = 32'sh1000_0000;  // 1.0 in Q4.28
  localparam logic signed [31:0] INIT_SLOPE_RST = -32'sd26642268;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_DX,
    OP_MUL_SD,
    OP_PHI,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_SQRT_INIT,
    OP_SQRT_STEP,
    OP_MUL_PS,
    OP_M,
    OP_MUL_LO,
    OP_ACC_LO,
    OP_MUL_HI,
    OP_SLOPE,
    OP_KEEP,
    OP_ZERO,
    OP_COMMIT,
    OP_START,
    OP_OUT
  } op_t;

  typedef enum logic [3:0] {
    C_NEXT,
    C_ALWAYS,
    C_NOACC,
    C_START,
    C_NORUN,
    C_PHASE1,
    C_NEGP,
    C_PXZ,
    C_LOOP,
    C_OUTBUSY
  } cnd_t;

  typedef struct packed {
    op_t  op;
    cnd_t cnd;
    pc_t  tgt;
  } uword_t;

  typedef struct packed {
    logic start;
    logic norun;
    logic phase1;
    logic negp;
    logic pxz;
    logic cnt_nz;
  } dp_flags_t;

  typedef struct packed {
    logic      acc;
    logic      out_busy;
    dp_flags_t dp;
  } stat_t;

  // program addresses
  localparam pc_t A_OUT       = 5'd0;
  localparam pc_t A_WAIT      = 5'd1;
  localparam pc_t A_DX        = 5'd2;
  localparam pc_t A_MUL_SD    = 5'd3;
  localparam pc_t A_PHI       = 5'd4;
  localparam pc_t A_DIV_INIT  = 5'd5;
  localparam pc_t A_PXZ       = 5'd6;
  localparam pc_t A_DIV_STEP  = 5'd7;
  localparam pc_t A_SQRT_INIT = 5'd8;
  localparam pc_t A_SQRT_STEP = 5'd9;
  localparam pc_t A_MUL_PS    = 5'd10;
  localparam pc_t A_M         = 5'd11;
  localparam pc_t A_MUL_LO    = 5'd12;
  localparam pc_t A_ACC_LO    = 5'd13;
  localparam pc_t A_MUL_HI    = 5'd14;
  localparam pc_t A_SLOPE     = 5'd15;
  localparam pc_t A_COMMIT    = 5'd16;
  localparam pc_t A_KEEP      = 5'd17;
  localparam pc_t A_ZERO      = 5'd18;
  localparam pc_t A_START     = 5'd19;

  // cond true -> jump to tgt, else fall through to pc+1
  function automatic uword_t rom_word(pc_t a);
    uword_t w;
    case (a)
      A_OUT:       w = '{op: OP_OUT,       cnd: C_OUTBUSY, tgt: A_OUT};
      A_WAIT:      w = '{op: OP_LATCH,     cnd: C_NOACC,   tgt: A_WAIT};
      A_DX:        w = '{op: OP_DX,        cnd: C_START,   tgt: A_START};
      A_MUL_SD:    w = '{op: OP_MUL_SD,    cnd: C_NORUN,   tgt: A_OUT};
      A_PHI:       w = '{op: OP_PHI,       cnd: C_PHASE1,  tgt: A_KEEP};
      A_DIV_INIT:  w = '{op: OP_DIV_INIT,  cnd: C_NEGP,    tgt: A_ZERO};
      A_PXZ:       w = '{op: OP_NONE,      cnd: C_PXZ,     tgt: A_KEEP};
      A_DIV_STEP:  w = '{op: OP_DIV_STEP,  cnd: C_LOOP,    tgt: A_DIV_STEP};
      A_SQRT_INIT: w = '{op: OP_SQRT_INIT, cnd: C_NEXT,    tgt: A_WAIT};
      A_SQRT_STEP: w = '{op: OP_SQRT_STEP, cnd: C_LOOP,    tgt: A_SQRT_STEP};
      A_MUL_PS:    w = '{op: OP_MUL_PS,    cnd: C_NEXT,    tgt: A_WAIT};
      A_M:         w = '{op: OP_M,         cnd: C_NEXT,    tgt: A_WAIT};
      A_MUL_LO:    w = '{op: OP_MUL_LO,    cnd: C_NEXT,    tgt: A_WAIT};
      A_ACC_LO:    w = '{op: OP_ACC_LO,    cnd: C_NEXT,    tgt: A_WAIT};
      A_MUL_HI:    w = '{op: OP_MUL_HI,    cnd: C_NEXT,    tgt: A_WAIT};
      A_SLOPE:     w = '{op: OP_SLOPE,     cnd: C_NEXT,    tgt: A_WAIT};
      A_COMMIT:    w = '{op: OP_COMMIT,    cnd: C_ALWAYS,  tgt: A_OUT};
      A_KEEP:      w = '{op: OP_KEEP,      cnd: C_ALWAYS,  tgt: A_COMMIT};
      A_ZERO:      w = '{op: OP_ZERO,      cnd: C_ALWAYS,  tgt: A_COMMIT};
      A_START:     w = '{op: OP_START,     cnd: C_ALWAYS,  tgt: A_OUT};
      default:     w = '{op: OP_NONE,      cnd: C_ALWAYS,  tgt: A_WAIT};
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/tfei_seq.sv
// ----------------------------------------------------------------------------
// tfei_seq
// Step counter and control store: fetches one control word per cycle and
// takes the conditional jump it names.
// ----------------------------------------------------------------------------
`default_nettype none

module tfei_seq (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire tfei_pkg::stat_t st,
  output tfei_pkg::uword_t     uw
);

  tfei_pkg::pc_t pc_r;
  tfei_pkg::pc_t pc_nxt;
  logic          take;

  assign uw = tfei_pkg::rom_word(pc_r);

  always_comb begin
    case (uw.cnd)
      tfei_pkg::C_NEXT:    take = 1'b0;
      tfei_pkg::C_ALWAYS:  take = 1'b1;
      tfei_pkg::C_NOACC:   take = !st.acc;
      tfei_pkg::C_START:   take = st.dp.start;
      tfei_pkg::C_NORUN:   take = st.dp.norun;
      tfei_pkg::C_PHASE1:  take = st.dp.phase1;
      tfei_pkg::C_NEGP:    take = st.dp.negp;
      tfei_pkg::C_PXZ:     take = st.dp.pxz;
      tfei_pkg::C_LOOP:    take = st.dp.cnt_nz;
      tfei_pkg::C_OUTBUSY: take = st.out_busy;
      default:             take = 1'b0;
    endcase
    pc_nxt = take ? uw.tgt : pc_r + tfei_pkg::PC_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= tfei_pkg::A_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/tfei_dp.sv
// ----------------------------------------------------------------------------
// tfei_dp
// Datapath: run state, one shared 33x33 multiplier, bit-serial divider and
// square root, clipping adders. Each control word selects one operation.
// ----------------------------------------------------------------------------
`default_nettype none

module tfei_dp (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [31:0]        cfg_wr_data,
  input  wire tfei_pkg::op_t      op,
  input  wire logic               in_acc,
  input  wire logic [31:0]        in_x,
  input  wire logic               in_start,
  output tfei_pkg::dp_flags_t     flags,
  output logic signed [31:0]      phi,
  output logic signed [31:0]      slope,
  output logic                    sticky
);

  // run state
  logic signed [31:0] init_slope_r;
  logic [31:0]        prev_x_r;
  logic signed [31:0] phi_r;
  logic signed [31:0] slope_r;
  tfei_pkg::phase_t   phase_r;
  logic               sticky_r;

  // per-item working registers
  logic [31:0]        x_r;
  logic               start_r;
  logic [31:0]        dx_r;
  logic signed [31:0] new_phi_r;
  logic signed [31:0] new_slope_r;
  logic               sat_phi_r;
  logic               sat_slp_r;
  logic signed [64:0] mul_r;
  logic [63:0]        dq_r;     // dividend/quotient, then radicand
  logic [31:0]        rem_r;
  logic [33:0]        srem_r;
  logic [31:0]        root_r;
  tfei_pkg::cnt_t     cnt_r;
  logic [41:0]        m_r;
  logic [39:0]        lo_r;

  // shared multiplier
  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] mul_p;

  // phi update
  logic               mul_neg;
  logic [63:0]        mag;
  logic [64:0]        mag_rnd;
  logic [44:0]        q;
  logic signed [46:0] phi_sum;
  logic               phi_hi;
  logic               phi_lo;
  logic signed [31:0] phi_clip;

  // slope update
  logic [50:0]        term;
  logic signed [52:0] slope_sum;
  logic               slp_hi;
  logic               slp_lo;
  logic signed [31:0] slope_clip;

  // divider / root steps
  logic [32:0]        dv_t;
  logic [32:0]        dv_diff;
  logic               dv_ge;
  logic [35:0]        sq_t;
  logic [35:0]        sq_trial;
  logic [35:0]        sq_diff;
  logic               sq_ge;

  always_comb begin
    case (op)
      tfei_pkg::OP_MUL_SD: begin
        mul_a = {slope_r[31], slope_r};
        mul_b = {1'b0, dx_r};
      end
      tfei_pkg::OP_MUL_PS: begin
        mul_a = {1'b0, phi_r};
        mul_b = {1'b0, root_r};
      end
      tfei_pkg::OP_MUL_LO: begin
        mul_a = {1'b0, m_r[31:0]};
        mul_b = {1'b0, dx_r};
      end
      tfei_pkg::OP_MUL_HI: begin
        mul_a = {23'b0, m_r[41:32]};
        mul_b = {1'b0, dx_r};
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    mul_p = mul_a * mul_b;
  end

  // phi + slope*dx, Q16.48 -> Q4.28 rounding half away from zero
  always_comb begin
    mul_neg  = mul_r[64];
    mag      = mul_neg ? 64'(-mul_r) : mul_r[63:0];
    mag_rnd  = {1'b0, mag} + 65'h8_0000;
    q        = mag_rnd[64:20];
    phi_sum  = mul_neg ? (47'(phi_r) - $signed({2'b0, q}))
                       : (47'(phi_r) + $signed({2'b0, q}));
    phi_hi   = phi_sum > 47'sd2147483647;
    phi_lo   = phi_sum < -47'sd2147483648;
    phi_clip = phi_hi ? 32'sh7FFF_FFFF : (phi_lo ? 32'sh8000_0000 : phi_sum[31:0]);
  end

  // term = (m*dx) >> 24 from the split products: hi*2^8 + lo>>24
  always_comb begin
    term       = {1'b0, mul_r[41:0], 8'b0} + 51'(lo_r);
    slope_sum  = 53'(slope_r) + $signed({2'b0, term});
    slp_hi     = slope_sum > 53'sd2147483647;
    slp_lo     = slope_sum < -53'sd2147483648;
    slope_clip = slp_hi ? 32'sh7FFF_FFFF : (slp_lo ? 32'sh8000_0000 : slope_sum[31:0]);
  end

  always_comb begin
    dv_t     = {rem_r, dq_r[63]};
    dv_ge    = dv_t >= {1'b0, prev_x_r};
    dv_diff  = dv_t - {1'b0, prev_x_r};
    sq_t     = {srem_r, dq_r[63:62]};
    sq_trial = {2'b0, root_r, 2'b01};
    sq_ge    = sq_t >= sq_trial;
    sq_diff  = sq_t - sq_trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_slope_r <= tfei_pkg::INIT_SLOPE_RST;
      prev_x_r     <= '0;
      phi_r        <= '0;
      slope_r      <= '0;
      phase_r      <= tfei_pkg::PH_IDLE;
      sticky_r     <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        init_slope_r <= cfg_wr_data;
      end
      case (op)
        tfei_pkg::OP_COMMIT: begin
          phi_r    <= new_phi_r;
          slope_r  <= new_slope_r;
          prev_x_r <= x_r;
          phase_r  <= (phase_r == tfei_pkg::PH_FIRST) ? tfei_pkg::PH_SECOND
                                                      : tfei_pkg::PH_LATER;
          sticky_r <= sticky_r | sat_phi_r | sat_slp_r;
        end
        tfei_pkg::OP_START: begin
          phi_r    <= tfei_pkg::PHI_ONE;
          slope_r  <= init_slope_r;
          prev_x_r <= x_r;
          phase_r  <= tfei_pkg::PH_FIRST;
          sticky_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      tfei_pkg::OP_LATCH: begin
        if (in_acc) begin
          x_r     <= in_x;
          start_r <= in_start;
        end
      end
      tfei_pkg::OP_DX: begin
        // a coordinate that goes backward steps by zero
        dx_r <= (x_r >= prev_x_r) ? x_r - prev_x_r : '0;
      end
      tfei_pkg::OP_MUL_SD, tfei_pkg::OP_MUL_PS,
      tfei_pkg::OP_MUL_LO, tfei_pkg::OP_MUL_HI: begin
        mul_r <= mul_p[64:0];
      end
      tfei_pkg::OP_PHI: begin
        new_phi_r <= phi_clip;
        sat_phi_r <= phi_hi | phi_lo;
        sat_slp_r <= 1'b0;
      end
      tfei_pkg::OP_DIV_INIT: begin
        rem_r <= '0;
        dq_r  <= {phi_r, 32'b0};
        cnt_r <= tfei_pkg::CNT_W'(tfei_pkg::DIV_STEPS - 1);
      end
      tfei_pkg::OP_DIV_STEP: begin
        rem_r <= dv_ge ? dv_diff[31:0] : dv_t[31:0];
        dq_r  <= {dq_r[62:0], dv_ge};
        cnt_r <= cnt_r - tfei_pkg::CNT_W'(1);
      end
      tfei_pkg::OP_SQRT_INIT: begin
        srem_r <= '0;
        root_r <= '0;
        cnt_r  <= tfei_pkg::CNT_W'(tfei_pkg::SQRT_STEPS - 1);
      end
      tfei_pkg::OP_SQRT_STEP: begin
        srem_r <= sq_ge ? sq_diff[33:0] : sq_t[33:0];
        root_r <= {root_r[30:0], sq_ge};
        dq_r   <= {dq_r[61:0], 2'b00};
        cnt_r  <= cnt_r - tfei_pkg::CNT_W'(1);
      end
      tfei_pkg::OP_M: begin
        m_r <= 42'(mul_r[63:22]) + 42'(mul_r[21]);
      end
      tfei_pkg::OP_ACC_LO: begin
        lo_r <= mul_r[63:24];
      end
      tfei_pkg::OP_SLOPE: begin
        new_slope_r <= slope_clip;
        sat_slp_r   <= slp_hi | slp_lo;
      end
      tfei_pkg::OP_KEEP: begin
        new_slope_r <= slope_r;
      end
      tfei_pkg::OP_ZERO: begin
        new_slope_r <= '0;
      end
      default: begin
      end
    endcase
  end

  assign flags.start  = start_r;
  assign flags.norun  = (phase_r == tfei_pkg::PH_IDLE);
  assign flags.phase1 = (phase_r == tfei_pkg::PH_FIRST);
  assign flags.negp   = phi_r[31];
  assign flags.pxz    = (prev_x_r == '0);
  assign flags.cnt_nz = (cnt_r != '0);

  assign phi    = phi_r;
  assign slope  = slope_r;
  assign sticky = sticky_r;

endmodule

`default_nettype wire

FILE: rtl/thomas_fermi_euler_integrator_core.sv
// A slope update runs the 64 divider and 32 root steps; a kept or zeroed slope,
// a start word or a word with no run skips them. One word in flight: the next
// accept comes in the cycle after the result is loaded; a result waiting in the
// output register does not block it. Reset (rst_n low, synchronous) clears the
// run and the output valid and loads the default initial slope.
// ----------------------------------------------------------------------------
// thomas_fermi_euler_integrator_core
// Forward-Euler Thomas-Fermi integrator, one grid point per input word,
// driven by a microcoded sequencer over a shared arithmetic datapath.
// ----------------------------------------------------------------------------
`default_nettype none

`include "thomas_fermi_euler_integrator_core_assert.svh"

module thomas_fermi_euler_integrator_core (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               cfg_wr_en,
  input  wire logic [31:0]        cfg_wr_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [31:0]        in_x_coord,
  input  wire logic               in_start_req,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic signed [31:0]      out_phi_value,
  output logic signed [31:0]      out_slope_value,
  output logic                    out_saturated
);

  tfei_pkg::uword_t    uw;
  tfei_pkg::stat_t     st;
  tfei_pkg::dp_flags_t flags;

  logic               in_acc;
  logic               out_load;
  logic signed [31:0] phi;
  logic signed [31:0] slope;
  logic               sticky;

  logic               out_valid_r;
  logic               out_valid_nxt;
  logic signed [31:0] out_phi_r;
  logic signed [31:0] out_slope_r;
  logic               out_sat_r;

  assign in_ready = (uw.op == tfei_pkg::OP_LATCH);
  assign in_acc   = in_valid && in_ready;
  assign out_load = (uw.op == tfei_pkg::OP_OUT) && (!out_valid_r || out_ready);

  assign st.acc      = in_acc;
  assign st.out_busy = out_valid_r && !out_ready;
  assign st.dp       = flags;

  tfei_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .st    (st),
    .uw    (uw)
  );

  tfei_dp u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .op          (uw.op),
    .in_acc      (in_acc),
    .in_x        (in_x_coord),
    .in_start    (in_start_req),
    .flags       (flags),
    .phi         (phi),
    .slope       (slope),
    .sticky      (sticky)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_phi_r   <= phi;
      out_slope_r <= slope;
      out_sat_r   <= sticky;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_phi_value   = out_phi_r;
  assign out_slope_value = out_slope_r;
  assign out_saturated   = out_sat_r;

  // one word in flight: an accept closes the input until its result is loaded
  `TFEI_ASSERT(a_one_in_flight, clk, rst_n, in_valid && in_ready |=> !in_ready)
  // a loaded result is presented on the next cycle
  `TFEI_ASSERT(a_load_shows, clk, rst_n, out_load |=> out_valid_r)
  // a new result only ever comes from the output step of the program
  `TFEI_ASSERT(a_rise_from_out, clk, rst_n,
               $rose(out_valid_r) |-> $past(uw.op == tfei_pkg::OP_OUT))

endmodule

`default_nettype wire

FILE: dv/tb_thomas_fermi_euler_integrator_core.sv
// ----------------------------------------------------------------------------
// tb_thomas_fermi_euler_integrator_core
// Drives grid points into the Euler integrator with random gaps and output
// stalls, predicts phi, slope and the clip flag of every point in fixed
// point, and checks each result word in order. The initial slope is set to
// several values, extremes included, between drained phases.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_thomas_fermi_euler_integrator_core;

  typedef struct packed {
    logic [31:0] x;
    logic        start;
  } grid_word_t;

  typedef struct packed {
    logic signed [31:0] phi;
    logic signed [31:0] slope;
    logic               sat;
  } point_word_t;

  logic               clk          = 1'b0;
  logic               rst_n        = 1'b0;
  logic               cfg_wr_en    = 1'b0;
  logic [31:0]        cfg_wr_data  = '0;
  logic               in_valid     = 1'b0;
  logic               in_ready;
  logic [31:0]        in_x_coord   = '0;
  logic               in_start_req = 1'b0;
  logic               out_valid;
  logic               out_ready    = 1'b0;
  logic signed [31:0] out_phi_value;
  logic signed [31:0] out_slope_value;
  logic               out_saturated;

  // integrator state as the testbench sees it
  logic signed [31:0] init_slope_q;
  logic [31:0]        last_x;
  logic signed [31:0] phi_q;
  logic signed [31:0] slope_q;
  tfei_pkg::phase_t   run_ph;
  logic               sat_q;

  grid_word_t  pending_words[$];
  point_word_t expected_points[$];
  grid_word_t  nxt;
  point_word_t want;
  int          fail_count = 0;
  int          send_gap   = 0;
  int          send_calm  = 0;
  int          recv_stall = 0;
  int          recv_calm  = 0;

  thomas_fermi_euler_integrator_core i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_wr_data     (cfg_wr_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_x_coord      (in_x_coord),
    .in_start_req    (in_start_req),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_phi_value   (out_phi_value),
    .out_slope_value (out_slope_value),
    .out_saturated   (out_saturated)
  );

  always #10 clk = ~clk;

  function automatic logic signed [31:0] clip_s32(input longint v, inout logic flag);
    if (v > longint'(32'sh7FFF_FFFF)) begin
      flag = 1'b1;
      return 32'sh7FFF_FFFF;
    end
    if (v < -longint'(64'h8000_0000)) begin
      flag = 1'b1;
      return 32'sh8000_0000;
    end
    return v[31:0];
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] v);
    logic [63:0] root;
    logic [63:0] trial;
    root = '0;
    for (int b = 31; b >= 0; b--) begin
      trial = root | (64'd1 << b);
      if (trial * trial <= v) root = trial;
    end
    return root;
  endfunction

  // one Euler step (or run start) for an accepted word; queues the result
  task automatic advance_point(input logic [31:0] x, input logic start);
    logic [31:0]        dx;
    longint             prod;
    longint             delta;
    logic [63:0]        mag;
    logic [63:0]        q;
    logic [63:0]        r;
    logic [63:0]        s;
    logic [63:0]        m;
    logic [95:0]        term_w;
    logic signed [31:0] nphi;
    logic signed [31:0] nslope;
    point_word_t        pw;
    if (start) begin
      last_x  = x;
      phi_q   = tfei_pkg::PHI_ONE;
      slope_q = init_slope_q;
      run_ph  = tfei_pkg::PH_FIRST;
      sat_q   = 1'b0;
    end else if (run_ph != tfei_pkg::PH_IDLE) begin
      dx    = (x >= last_x) ? x - last_x : '0;
      prod  = longint'(slope_q) * longint'({32'b0, dx});
      mag   = (prod < 0) ? -prod : prod;
      // Q16.48 -> Q4.28, half away from zero
      q     = (mag + 64'd524288) >> 20;
      delta = (prod < 0) ? -longint'(q) : longint'(q);
      nphi  = clip_s32(longint'(phi_q) + delta, sat_q);
      if (run_ph == tfei_pkg::PH_FIRST) begin
        nslope = slope_q;
      end else if (phi_q < 0) begin
        nslope = '0;
      end else if (last_x == 0) begin
        nslope = slope_q;
      end else begin
        r      = {phi_q, 32'b0} / {32'b0, last_x};
        s      = int_sqrt(r);
        m      = ({32'b0, phi_q} * s + 64'd2097152) >> 22;
        term_w = {32'b0, m} * {64'b0, dx};
        nslope = clip_s32(longint'(slope_q) + longint'(term_w[87:24]), sat_q);
      end
      phi_q   = nphi;
      slope_q = nslope;
      last_x  = x;
      run_ph  = (run_ph == tfei_pkg::PH_FIRST) ? tfei_pkg::PH_SECOND : tfei_pkg::PH_LATER;
    end
    pw.phi   = phi_q;
    pw.slope = slope_q;
    pw.sat   = sat_q;
    expected_points.push_back(pw);
  endtask

  // mostly no idle, some short, a few long; occasional quiet stretches
  function automatic int idle_len(inout int calm);
    int r;
    if (calm > 0) begin
      calm--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 4) begin
      calm = $urandom_range(80, 20);
      return 0;
    end
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(20, 4);
    return $urandom_range(300, 50);
  endfunction

  function automatic logic [31:0] next_grid_x(input logic [31:0] x, input int kind);
    logic [32:0] nx;
    case ($urandom_range(31))
      0: return x - $urandom_range(1 << 20);
      1: return x;
      2: return $urandom;
      default: ;
    endcase
    case (kind)
      0:       nx = x + $urandom_range(1 << 18, 1 << 10);
      1:       nx = x + $urandom_range(1 << 24);
      default: nx = x + $urandom_range(1 << 28);
    endcase
    return nx[32] ? 32'hFFFF_FFFF : nx[31:0];
  endfunction

  task automatic add_word(input logic [31:0] x, input logic start);
    pending_words.push_back('{x: x, start: start});
  endtask

  // mostly whole runs (start, then mostly rising x), the rest loose words
  task automatic queue_runs(input int n);
    int          added;
    int          len;
    int          kind;
    logic [31:0] x;
    added = 0;
    while (added < n) begin
      if ($urandom_range(99) < 88) begin
        case ($urandom_range(3))
          0, 1:    x = '0;
          2:       x = $urandom_range(1 << 24);
          default: x = $urandom;
        endcase
        add_word(x, 1'b1);
        len  = $urandom_range(24, 2);
        kind = $urandom_range(2);
        repeat (len) begin
          x = next_grid_x(x, kind);
          add_word(x, 1'b0);
        end
        added += len + 1;
      end else begin
        add_word($urandom, 1'($urandom_range(1)));
        added++;
      end
    end
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_words.size() != 0 || in_valid || expected_points.size() != 0);
  endtask

  task automatic write_slope(input logic [31:0] v);
    @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // input side: predictor update on accept, then next word or gap
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid     <= 1'b0;
      in_x_coord   <= '0;
      in_start_req <= 1'b0;
      send_gap     = 0;
      init_slope_q = tfei_pkg::INIT_SLOPE_RST;
      last_x       = '0;
      phi_q        = '0;
      slope_q      = '0;
      run_ph       = tfei_pkg::PH_IDLE;
      sat_q        = 1'b0;
    end else begin
      if (cfg_wr_en) init_slope_q = cfg_wr_data;
      if (in_valid && in_ready) advance_point(in_x_coord, in_start_req);
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (pending_words.size() != 0) begin
          nxt          = pending_words.pop_front();
          in_x_coord   <= nxt.x;
          in_start_req <= nxt.start;
          in_valid     <= 1'b1;
          send_gap     = idle_len(send_calm);
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result side: compare against oldest prediction, random backpressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready  <= 1'b0;
      recv_stall = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_points.size() == 0) begin
          fail_count++;
          if (fail_count <= 10)
            $display("%0t: unexpected result word: phi %h slope %h sat %b", $time,
                     out_phi_value, out_slope_value, out_saturated);
        end else begin
          want = expected_points.pop_front();
          if (out_phi_value !== want.phi || out_slope_value !== want.slope ||
              out_saturated !== want.sat) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch: phi exp %h got %h, slope exp %h got %h, sat exp %b got %b",
                       $time, want.phi, out_phi_value, want.slope, out_slope_value,
                       want.sat, out_saturated);
          end
        end
        recv_stall = idle_len(recv_calm);
      end else if (recv_stall == 0 && $urandom_range(15) == 0) begin
        recv_stall = idle_len(recv_calm);
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin : main_seq
    logic [31:0] slope_setting;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    add_word(32'h1234_5678, 1'b0);  // no run yet: state untouched
    add_word(32'hFFFF_FFFF, 1'b0);
    add_word(32'h0000_0000, 1'b1);
    add_word(32'h0000_0000, 1'b0);  // first step keeps slope, dx = 0
    add_word(32'h0000_0000, 1'b0);  // prev x at origin: slope kept
    add_word(32'h0040_0000, 1'b0);
    add_word(32'h0080_0000, 1'b0);  // full slope update
    add_word(32'h0060_0000, 1'b0);  // x steps back, dx forced to 0
    add_word(32'h0100_0000, 1'b0);
    add_word(32'h0800_0000, 1'b0);  // long step drives phi further below zero
    add_word(32'h1000_0000, 1'b0);  // negative phi clears slope
    add_word(32'hFFFF_FFFF, 1'b0);
    add_word(32'hFFFF_FFFF, 1'b1);
    add_word(32'hFFFF_FFFF, 1'b0);
    add_word(32'h0000_0000, 1'b1);
    add_word(32'hFFFF_FFFF, 1'b0);  // phi clips at the low end
    add_word(32'hFFFF_FFFF, 1'b0);
    add_word(32'h0000_0001, 1'b1);  // new run drops the sticky flag
    add_word(32'h0000_0002, 1'b0);
    add_word(32'h0000_0003, 1'b0);
    add_word(32'hFFFF_FFFF, 1'b0);  // tiny prev x, huge step: slope clips high

    for (int ph = 0; ph < 7; ph++) begin
      if (ph > 0) begin
        wait_drained();
        case (ph)
          1:       slope_setting = 32'h8000_0000;
          2:       slope_setting = 32'h7FFF_FFFF;
          3:       slope_setting = 32'h0000_0000;
          4:       slope_setting = $urandom;
          default: slope_setting = -(32'd25000000 + $urandom_range(3000000));
        endcase
        write_slope(slope_setting);
      end
      queue_runs(100);
    end

    wait_drained();
    repeat (150) @(posedge clk);
    if (expected_points.size() != 0) begin
      fail_count += expected_points.size();
      $display("%0d result words never arrived", expected_points.size());
    end
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

  initial begin
    #60_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

`default_nettype wire

FILE: files.f
+incdir+rtl
rtl/tfei_pkg.sv
rtl/tfei_seq.sv
rtl/tfei_dp.sv
rtl/thomas_fermi_euler_integrator_core.sv
dv/tb_thomas_fermi_euler_integrator_core.sv
